// ===== rtl/cdf_pkg.sv =====
`timescale 1ns / 1ps

package cdf_pkg;

    // Fixed-point format of the probability table and the uniforms
    localparam int FRAC_BITS       = 24;
    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int IDX_OUT_W       = 10;
    localparam int STEP_W          = $clog2(FRAC_BITS);

    localparam logic [FRAC_BITS:0]   ONE_Q     = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] MAX_BELOW = '1;

    // Action codes
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    // Status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_SQRT,
        ST_MUL,
        ST_FORM,
        ST_RESULT
    } state_t;

endpackage

// ===== rtl/cdf_triangle_sampler_unit.sv =====
`timescale 1ns / 1ps

// Discrete CDF sampler with uniform-triangle barycentric output.
// Input channel (in_valid / in_stall) carries one command per transaction:
// clear the table, append one probability, or query with two uniforms.
// Output channel (out_valid / out_stall) returns exactly one result per
// command, in order, from an output register.
// Every command but a query on a non-empty table goes straight to the
// result state, where its result is registered once the output register
// is free; the next command is taken back in idle. A query scans the table
// memory one entry per cycle, then runs a restoring division (skipped
// when the remap is zero or saturated), a square root, the multiply and
// the forming step before the result state. The single memory read port
// sets the pace of the scan.
// One command is in flight at a time; a new one is taken while the previous
// result still sits in the output register.
// Reset empties the table (count and running sum to zero); stored values
// are not cleared and are never read beyond the count.
// A stalled receiver holds the result; a finished command then waits until
// the output register frees up.
module cdf_triangle_sampler_unit #(
    parameter int MAX_ENTRIES = cdf_pkg::MAX_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     action,
    input  logic [cdf_pkg::FRAC_BITS:0]    probability,
    input  logic                           mark_final,
    input  logic [cdf_pkg::FRAC_BITS-1:0]  u_select,
    input  logic [cdf_pkg::FRAC_BITS-1:0]  u_second,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [cdf_pkg::IDX_OUT_W-1:0]  entry_index,
    output logic [cdf_pkg::FRAC_BITS-1:0]  local_uniform,
    output logic [cdf_pkg::FRAC_BITS:0]    weight_b0,
    output logic [cdf_pkg::FRAC_BITS:0]    weight_b1,
    output logic [cdf_pkg::FRAC_BITS:0]    weight_b2
);
    import cdf_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int F     = FRAC_BITS;

    state_t state_reg, state_next;

    // Table memory
    logic [F:0]       mem [MAX_ENTRIES];
    logic [F:0]       rdata_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [F:0]       wr_data;

    // Control state
    logic [CNT_W-1:0] count_reg;
    logic [F:0]       sum_reg;
    logic             out_valid_reg;

    // Query working registers
    logic [F-1:0]     u1_reg, u2_reg;
    logic [IDX_W-1:0] last_reg, scan_addr_reg, data_idx_reg, idx_reg;
    logic             rd_pending_reg;
    logic [F:0]       prev_reg, width_reg;
    logic [F+1:0]     drem_reg;
    logic [F-1:0]     quo_reg, local_reg, root_reg;
    logic [2*F-1:0]   v_reg, prod_reg;
    logic [F+3:0]     srem_reg;
    logic [STEP_W-1:0] step_reg;

    // Pending result
    logic [1:0]       res_status;
    logic [IDX_W-1:0] res_idx;
    logic [F-1:0]     res_local;
    logic [F:0]       res_b0, res_b1, res_b2;

    logic accept, slot_free, is_query_go, last_step;
    logic full;
    logic [F+1:0] sum_wide;
    logic [F:0]   sum_sat;

    // Scan comparison
    logic [F:0] u1_ext, width_c, diff_c;
    logic       hit, need_div, sat_local, found;

    // Iteration steps
    logic [F+1:0] drem_sh, drem_new;
    logic         qbit;
    logic [F-1:0] quo_done;
    logic [F+3:0] srem_sh, trial;
    logic         rbit;

    assign accept      = in_valid && !in_stall;
    assign slot_free   = !out_valid_reg || !out_stall;
    assign full        = count_reg >= CNT_W'(MAX_ENTRIES);
    assign is_query_go = (action == ACT_QUERY) && (count_reg != '0);
    assign last_step   = step_reg == STEP_W'(F - 1);

    // Append arithmetic
    assign sum_wide = {1'b0, sum_reg} + {1'b0, probability};
    assign sum_sat  = (sum_wide > {1'b0, ONE_Q}) ? ONE_Q : sum_wide[F:0];
    assign wr_en    = accept && (action == ACT_APPEND) && !full;
    assign wr_data  = mark_final ? ONE_Q : sum_sat;

    // Scan: entry data_idx_reg is in rdata_reg
    assign u1_ext    = {1'b0, u1_reg};
    assign hit       = (rdata_reg >= u1_ext) || (data_idx_reg == last_reg);
    assign found     = (state_reg == ST_SCAN) && rd_pending_reg && hit;
    assign width_c   = (rdata_reg > prev_reg) ? (rdata_reg - prev_reg) : '0;
    assign diff_c    = u1_ext - prev_reg;
    assign need_div  = (width_c != '0) && (u1_ext > prev_reg) && (diff_c < width_c);
    assign sat_local = (width_c != '0) && (u1_ext > prev_reg) && (diff_c >= width_c);

    // Restoring division step
    assign drem_sh  = {drem_reg[F:0], 1'b0};
    assign qbit     = drem_sh >= {1'b0, width_reg};
    assign drem_new = qbit ? (drem_sh - {1'b0, width_reg}) : drem_sh;
    assign quo_done = {quo_reg[F-2:0], qbit};

    // Square root step, two radicand bits per step
    assign srem_sh = {srem_reg[F+1:0], v_reg[2*F-1:2*F-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign rbit    = srem_sh >= trial;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = is_query_go ? ST_SCAN : ST_RESULT;
            end
            ST_SCAN:
            begin
                if (found)
                    state_next = need_div ? ST_DIV : ST_SQRT;
            end
            ST_DIV:    if (last_step) state_next = ST_SQRT;
            ST_SQRT:   if (last_step) state_next = ST_MUL;
            ST_MUL:    state_next = ST_FORM;
            ST_FORM:   state_next = ST_RESULT;
            ST_RESULT: if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        rd_addr  = scan_addr_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && action == ACT_CLEAR)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
            end
            else if (wr_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
                sum_reg   <= sum_sat;
            end
            if (state_reg == ST_RESULT && slot_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Table memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[IDX_W-1:0]] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    // Query datapath and pending result
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                rd_pending_reg <= 1'b0;
                scan_addr_reg  <= '0;
                prev_reg       <= '0;
                u1_reg         <= u_select;
                u2_reg         <= u_second;
                last_reg       <= IDX_W'(count_reg - CNT_W'(1));
                res_status     <= STS_OK;
                res_idx        <= '0;
                res_local      <= '0;
                res_b0         <= '0;
                res_b1         <= '0;
                res_b2         <= '0;
                if (action == ACT_APPEND)
                begin
                    if (full)
                        res_status <= STS_FULL;
                    else
                        res_idx <= count_reg[IDX_W-1:0];
                end
                else if (action == ACT_QUERY && count_reg == '0)
                    res_status <= STS_EMPTY;
            end
            ST_SCAN:
            begin
                rd_pending_reg <= 1'b1;
                data_idx_reg   <= scan_addr_reg;
                if (scan_addr_reg != last_reg)
                    scan_addr_reg <= scan_addr_reg + IDX_W'(1);
                if (rd_pending_reg)
                begin
                    if (hit)
                    begin
                        idx_reg   <= data_idx_reg;
                        width_reg <= width_c;
                        drem_reg  <= {1'b0, diff_c};
                        step_reg  <= '0;
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        if (sat_local)
                        begin
                            local_reg <= MAX_BELOW;
                            v_reg     <= {MAX_BELOW, F'(0)};
                        end
                        else
                        begin
                            local_reg <= '0;
                            v_reg     <= '0;
                        end
                    end
                    else
                        prev_reg <= rdata_reg;
                end
            end
            ST_DIV:
            begin
                drem_reg <= drem_new;
                quo_reg  <= quo_done;
                step_reg <= step_reg + STEP_W'(1);
                if (last_step)
                begin
                    local_reg <= quo_done;
                    v_reg     <= {quo_done, F'(0)};
                    step_reg  <= '0;
                end
            end
            ST_SQRT:
            begin
                v_reg    <= {v_reg[2*F-3:0], 2'b00};
                srem_reg <= rbit ? (srem_sh - trial) : srem_sh;
                root_reg <= {root_reg[F-2:0], rbit};
                step_reg <= step_reg + STEP_W'(1);
            end
            ST_MUL:
            begin
                prod_reg <= u2_reg * root_reg;
            end
            ST_FORM:
            begin
                res_status <= STS_OK;
                res_idx    <= idx_reg;
                res_local  <= local_reg;
                res_b0     <= ONE_Q - {1'b0, root_reg};
                res_b1     <= {1'b0, prod_reg[2*F-1:F]};
                res_b2     <= {1'b0, root_reg} - {1'b0, prod_reg[2*F-1:F]};
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RESULT && slot_free)
        begin
            status        <= res_status;
            entry_index   <= IDX_OUT_W'(res_idx);
            local_uniform <= res_local;
            weight_b0     <= res_b0;
            weight_b1     <= res_b1;
            weight_b2     <= res_b2;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> state_reg == ST_IDLE)
        else $error("command accepted while busy");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STS_OK |-> weight_b0 == '0 && weight_b1 == '0
            && weight_b2 == '0 && local_uniform == '0)
        else $error("error result carries nonzero fields");

    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RESULT && res_status == STS_OK && res_b0 != '0 |->
            res_b0 + res_b1 + res_b2 == ONE_Q)
        else $error("barycentrics do not sum to one");
`endif

endmodule

// ===== verif/tb_cdf_triangle_sampler_unit.sv =====
`timescale 1ns / 1ps

module tb_cdf_triangle_sampler_unit;

    import cdf_pkg::*;

    localparam int TAB_DEPTH = 1024;

    // Action code outside the defined set
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  act;
        logic [24:0] prob;
        logic        fin;
        logic [23:0] u1;
        logic [23:0] u2;
    } cmd_t;

    typedef struct {
        logic [1:0]  status;
        logic [9:0]  idx;
        logic [23:0] loc;
        logic [24:0] b0;
        logic [24:0] b1;
        logic [24:0] b2;
    } sample_t;

    // Directed row: command plus an optional typed expectation
    typedef struct {
        cmd_t    cmd;
        bit      typed;
        sample_t res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [24:0] probability;
    logic        mark_final;
    logic [23:0] u_select;
    logic [23:0] u_second;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [9:0]  entry_index;
    logic [23:0] local_uniform;
    logic [24:0] weight_b0;
    logic [24:0] weight_b1;
    logic [24:0] weight_b2;

    // Predictor state
    logic [24:0] cdf_tab [TAB_DEPTH];
    int unsigned tab_count;
    logic [24:0] run_sum;

    sample_t     pending_q[$];
    row_t        dir_rows[$];
    int          fail_cnt;
    bit          quiet;
    int          n_query;
    int          n_append;
    int          n_full;
    int          n_empty;
    int          n_cmd;

    cdf_triangle_sampler_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .probability   (probability),
        .mark_final    (mark_final),
        .u_select      (u_select),
        .u_second      (u_second),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .entry_index   (entry_index),
        .local_uniform (local_uniform),
        .weight_b0     (weight_b0),
        .weight_b1     (weight_b1),
        .weight_b2     (weight_b2)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Integer square root, digit by digit
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Table update and sample computation for one command
    function automatic sample_t sample_predict(cmd_t c);
        sample_t         r;
        longint unsigned s, prev, cur, width, diff, loc, root, b1, one;
        int unsigned     sel;
        r     = '{default: '0};
        one   = longint'(ONE_Q);
        loc   = 0;
        case (c.act)
            ACT_CLEAR:
            begin
                tab_count = 0;
                run_sum   = '0;
            end
            ACT_APPEND:
            begin
                if (tab_count >= TAB_DEPTH)
                    r.status = STS_FULL;
                else
                begin
                    s = longint'(run_sum) + longint'(c.prob);
                    if (s > one) s = one;
                    run_sum            = 25'(s);
                    cdf_tab[tab_count] = c.fin ? ONE_Q : 25'(s);
                    r.idx              = 10'(tab_count);
                    tab_count++;
                end
            end
            ACT_QUERY:
            begin
                if (tab_count == 0)
                    r.status = STS_EMPTY;
                else
                begin
                    sel = tab_count - 1;
                    for (int i = 0; i < tab_count; i++)
                    begin
                        if (cdf_tab[i] >= {1'b0, c.u1})
                        begin
                            sel = i;
                            break;
                        end
                    end
                    prev  = (sel == 0) ? 0 : longint'(cdf_tab[sel-1]);
                    cur   = longint'(cdf_tab[sel]);
                    width = (cur > prev) ? cur - prev : 0;
                    if (width > 0 && longint'(c.u1) > prev)
                    begin
                        diff = longint'(c.u1) - prev;
                        if (diff >= width)
                            loc = longint'(MAX_BELOW);
                        else
                        begin
                            loc = (diff << FRAC_BITS) / width;
                            if (loc > longint'(MAX_BELOW)) loc = longint'(MAX_BELOW);
                        end
                    end
                    root = int_sqrt(loc << FRAC_BITS);
                    if (root > one) root = one;
                    b1    = (longint'(c.u2) * root) >> FRAC_BITS;
                    r.idx = 10'(sel);
                    r.loc = 24'(loc);
                    r.b0  = 25'(one - root);
                    r.b1  = 25'(b1);
                    r.b2  = 25'(root - b1);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Drive one transaction: random gap, then hold until accepted
    task automatic send_cmd(cmd_t c, bit typed, sample_t tres);
        int      gap;
        sample_t p;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action      = c.act;
        probability = c.prob;
        mark_final  = c.fin;
        u_select    = c.u1;
        u_second    = c.u2;
        in_valid    = 1'b1;
        do @(posedge clk); while (in_stall);
        p = sample_predict(c);
        pending_q.insert(pending_q.size(), typed ? tres : p);
        n_cmd++;
        if (c.act == ACT_QUERY) n_query++;
        if (c.act == ACT_APPEND) n_append++;
        if (p.status == STS_FULL) n_full++;
        if (p.status == STS_EMPTY) n_empty++;
        @(negedge clk);
    endtask

    function automatic cmd_t mk(logic [1:0] a, logic [24:0] pr, logic f,
                                logic [23:0] x, logic [23:0] y);
        cmd_t c;
        c.act  = a;
        c.prob = pr;
        c.fin  = f;
        c.u1   = x;
        c.u2   = y;
        return c;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(cmd_t c, bit typed, sample_t r);
        dir_rows.insert(dir_rows.size(), '{c, typed, r});
    endfunction

    // Result checker with random receiver stalls
    initial
    begin
        sample_t e;
        int      n;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 15);
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: status %0d index %0d", status, entry_index);
                fail_cnt++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, status);
                    fail_cnt++;
                end
                if (entry_index !== e.idx)
                begin
                    $error("entry_index: expected %0d, got %0d", e.idx, entry_index);
                    fail_cnt++;
                end
                if (local_uniform !== e.loc)
                begin
                    $error("local_uniform: expected %0d, got %0d", e.loc, local_uniform);
                    fail_cnt++;
                end
                if (weight_b0 !== e.b0)
                begin
                    $error("weight_b0: expected %0d, got %0d", e.b0, weight_b0);
                    fail_cnt++;
                end
                if (weight_b1 !== e.b1)
                begin
                    $error("weight_b1: expected %0d, got %0d", e.b1, weight_b1);
                    fail_cnt++;
                end
                if (weight_b2 !== e.b2)
                begin
                    $error("weight_b2: expected %0d, got %0d", e.b2, weight_b2);
                    fail_cnt++;
                end
            end
            @(negedge clk);
        end
    end

    // Watchdog
    initial
    begin
        #10ms;
        $display("cdf_triangle_sampler_unit: mismatch");
        $finish;
    end

    // Stimulus
    initial
    begin
        sample_t z;
        sample_t t;
        cmd_t    c;
        int      len;
        int      waited;
        logic [24:0] pmax;

        z           = '{default: '0};
        tab_count   = 0;
        run_sum     = '0;
        fail_cnt    = 0;
        quiet       = 1'b0;
        n_query     = 0;
        n_append    = 0;
        n_full      = 0;
        n_empty     = 0;
        n_cmd       = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_CLEAR;
        probability = '0;
        mark_final  = 1'b0;
        u_select    = '0;
        u_second    = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: empty query, clear, saturation, final mark,
        // zero width, uniform at both ends, unused action, probability above one
        t = z; t.status = STS_EMPTY;
        add_row(mk(ACT_QUERY, 0, 0, 24'h123456, 24'hFFFFFF), 1, t);
        add_row(mk(ACT_CLEAR, 0, 0, 0, 0), 1, z);
        t = z; t.idx = 0;
        add_row(mk(ACT_APPEND, 0, 0, 0, 0), 1, t);
        t = z; t.b0 = ONE_Q;
        add_row(mk(ACT_QUERY, 0, 0, 24'h0, 24'hFFFFFF), 1, t);
        t = z; t.idx = 1;
        add_row(mk(ACT_APPEND, ONE_Q, 0, 0, 0), 1, t);
        t = z; t.idx = 2;
        add_row(mk(ACT_APPEND, 25'd5000, 0, 0, 0), 1, t);
        add_row(mk(ACT_QUERY, 0, 0, 24'hFFFFFF, 24'h0), 0, z);
        add_row(mk(ACT_QUERY, 0, 0, 24'h000001, 24'hFFFFFF), 0, z);
        add_row(mk(ACT_CLEAR, 0, 0, 0, 0), 1, z);
        t = z; t.idx = 0;
        add_row(mk(ACT_APPEND, 25'h400000, 0, 0, 0), 1, t);
        t = z; t.idx = 1;
        add_row(mk(ACT_APPEND, 25'h400000, 0, 0, 0), 1, t);
        t = z; t.idx = 2;
        add_row(mk(ACT_APPEND, 25'h400000, 1, 0, 0), 1, t);
        add_row(mk(ACT_QUERY, 0, 0, 24'h200000, 24'h800000), 0, z);
        add_row(mk(ACT_QUERY, 0, 0, 24'h600000, 24'hFFFFFF), 0, z);
        add_row(mk(ACT_QUERY, 0, 0, 24'hFFFFFF, 24'h7FFFFF), 0, z);
        t = z; t.idx = 3;
        add_row(mk(ACT_APPEND, 25'h0AAAAAA, 0, 0, 0), 1, t);
        add_row(mk(ACT_QUERY, 0, 0, 24'hF00000, 24'h555555), 0, z);
        add_row(mk(ACT_QUERY, 0, 0, 24'h000000, 24'h000000), 0, z);
        add_row(mk(ACT_UNUSED, 25'h1FFFFFF, 1, 24'hFFFFFF, 24'hFFFFFF), 1, z);
        t = z; t.idx = 4;
        add_row(mk(ACT_APPEND, 25'h1FFFFFF, 0, 0, 0), 1, t);
        add_row(mk(ACT_QUERY, 0, 0, 24'hFFFFFF, 24'h123456), 0, z);
        add_row(mk(ACT_CLEAR, 0, 0, 0, 0), 1, z);
        foreach (dir_rows[i])
            send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);

        // Random part: mostly clear / build / query sequences, some noise
        while (n_cmd < 120)
        begin
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                c = mk(2'($urandom_range(0, 2)), 25'($urandom_range(0, 32'h1000000)),
                       1'($urandom), 24'($urandom), 24'($urandom));
                send_cmd(c, 0, z);
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    send_cmd(mk(ACT_CLEAR, 0, 0, 0, 0), 0, z);
                len  = $urandom_range(1, 12);
                pmax = ($urandom_range(0, 2) == 0) ? ONE_Q : 25'h3FFFFF;
                for (int k = 0; k < len; k++)
                begin
                    c = mk(ACT_APPEND, 25'($urandom_range(0, 32'(pmax))),
                           (k == len - 1) && ($urandom_range(0, 1) == 1), 0, 0);
                    send_cmd(c, 0, z);
                end
                len = $urandom_range(2, 8);
                for (int k = 0; k < len; k++)
                begin
                    c = mk(ACT_QUERY, 0, 0, 24'($urandom), 24'($urandom));
                    send_cmd(c, 0, z);
                end
            end
        end
        quiet = 1'b0;

        // Fill the table to its depth, then one append too many
        send_cmd(mk(ACT_CLEAR, 0, 0, 0, 0), 0, z);
        for (int k = 0; k <= TAB_DEPTH; k++)
            send_cmd(mk(ACT_APPEND, 25'($urandom_range(0, 16383)), 0, 0, 0), 0, z);
        for (int k = 0; k < 3; k++)
            send_cmd(mk(ACT_QUERY, 0, 0, 24'($urandom), 24'($urandom)), 0, z);
        send_cmd(mk(ACT_CLEAR, 0, 0, 0, 0), 0, z);
        in_valid = 1'b0;

        // Drain, then let any stray result show up
        waited = 0;
        while (pending_q.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (1200) @(posedge clk);

        $display("ran %0d transactions: %0d appends, %0d queries", n_cmd, n_append, n_query);
        $display("full-table appends %0d, empty-table queries %0d", n_full, n_empty);
        if (fail_cnt == 0 && pending_q.size() == 0)
            $display("cdf_triangle_sampler_unit: match");
        else
            $display("cdf_triangle_sampler_unit: mismatch");
        $finish;
    end

endmodule
